### rtl/iia_pkg.sv
// ----------------------------------------------------------------------------
// iia_pkg
// Shared types and constants of the iterative integer ALU.
// ----------------------------------------------------------------------------
package iia_pkg;

    localparam int unsigned OP_W   = 3;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_SQR = 3'd4,
        OP_POW = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SER,
        S_MUL,
        S_DIV,
        S_PCHK,
        S_PMUL,
        S_PSQR,
        S_DONE
    } t_state;

endpackage

### rtl/iia_if.sv
// ----------------------------------------------------------------------------
// iia_req_if / iia_rsp_if
// Valid/ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
interface iia_req_if;
    import iia_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     req_type;
    logic [DATA_W-1:0]   operand_a;
    logic [DATA_W-1:0]   operand_b;
    logic [DATA_W-1:0]   exponent;

    modport source (output valid, req_type, operand_a, operand_b, exponent,
                    input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, exponent,
                    output ready);
endinterface

interface iia_rsp_if;
    import iia_pkg::*;
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   result;
    logic                divide_by_zero;

    modport source (output valid, result, divide_by_zero, input ready);
    modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

### rtl/iia_mul.sv
// ----------------------------------------------------------------------------
// iia_mul
// Shift-add multiplier, one multiplier bit per cycle, product mod 2^WIDTH.
// ----------------------------------------------------------------------------
module iia_mul #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic             o_done,
    output logic [WIDTH-1:0] o_prod
);
    localparam int unsigned CW = $clog2(WIDTH);

    logic             r_busy, r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_mc, r_mp, r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(WIDTH - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // add the shifted multiplicand where the multiplier bit is set
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mc  <= i_a;
            r_mp  <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_mp[0]) r_acc <= r_acc + r_mc;
            r_mc <= {r_mc[WIDTH-2:0], 1'b0};
            r_mp <= {1'b0, r_mp[WIDTH-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### rtl/iia_div.sv
// ----------------------------------------------------------------------------
// iia_div
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module iia_div #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_n,
    input  logic [WIDTH-1:0] i_d,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quo
);
    localparam int unsigned CW = $clog2(WIDTH);

    logic             r_busy, r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH:0]   r_rem;
    logic [WIDTH-1:0] r_q, r_d;
    logic [WIDTH:0]   w_sh, w_diff;
    logic             w_fit;

    assign w_sh   = {r_rem[WIDTH-1:0], r_q[WIDTH-1]};
    assign w_diff = w_sh - {1'b0, r_d};
    assign w_fit  = (w_sh >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(WIDTH - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // dividend bits leave the top of r_q as quotient bits enter the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_n;
            r_d   <= i_d;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff : w_sh;
            r_q   <= {r_q[WIDTH-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

### rtl/iterative_integer_alu_core.sv
// ----------------------------------------------------------------------------
// iterative_integer_alu_core
// Bit-serial ALU: add, subtract, multiply, divide, square and power,
// all results modulo 2^WIDTH.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  i_req   | in  | valid/ready  | req_type, operand_a, operand_b, exponent
//  o_rsp   | out | valid/ready  | result, divide_by_zero
//
//  Add and subtract ripple one bit per cycle.
//  Multiply and square run on the shared shift-add unit, divide on the
//  restoring unit.
//  Power loops over the exponent bits: per bit one or two multiplies on the
//  single multiplier.
//  Divide by zero and unused codes go straight to the done state.
//  One item at a time; ready is high only when the sequencer is idle. The
//  response register frees the sequencer while a result waits downstream.
//  Reset is synchronous, active low, and clears control state only.
// ----------------------------------------------------------------------------
module iterative_integer_alu_core #(
    parameter int unsigned WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iia_req_if.sink   i_req,
    iia_rsp_if.source o_rsp
);
    import iia_pkg::*;

    localparam int unsigned CW = $clog2(WIDTH);

    // operands reduced to the working width
    logic [WIDTH-1:0] w_a, w_b;
    assign w_a = WIDTH'(i_req.operand_a);
    assign w_b = WIDTH'(i_req.operand_b);

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [WIDTH-1:0] r_a, n_a, r_b, n_b;
    logic [DATA_W-1:0] r_e, n_e;
    logic [WIDTH-1:0] r_res, n_res, r_acc, n_acc, r_base, n_base;
    logic             r_dz, n_dz, r_carry, n_carry;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_res, n_out_res;
    logic             r_out_dz, n_out_dz;

    logic             mul_start, mul_done, div_start, div_done;
    logic [WIDTH-1:0] mul_a, mul_b, mul_prod, div_quo;
    logic             w_bit, w_cout;

    iia_mul #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    iia_div #(.WIDTH(WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n     (w_a),
        .i_d     (w_b),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // serial sum or difference bit and its carry / borrow
    always_comb begin
        w_bit = r_a[0] ^ r_b[0] ^ r_carry;
        if (r_op == OP_SUB) begin
            w_cout = (~r_a[0] & r_b[0]) | (~(r_a[0] ^ r_b[0]) & r_carry);
        end else begin
            w_cout = (r_a[0] & r_b[0]) | ((r_a[0] ^ r_b[0]) & r_carry);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_a       <= n_a;
        r_b       <= n_b;
        r_e       <= n_e;
        r_res     <= n_res;
        r_acc     <= n_acc;
        r_base    <= n_base;
        r_dz      <= n_dz;
        r_carry   <= n_carry;
        r_cnt     <= n_cnt;
        r_out_res <= n_out_res;
        r_out_dz  <= n_out_dz;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_e         = r_e;
        n_res       = r_res;
        n_acc       = r_acc;
        n_base      = r_base;
        n_dz        = r_dz;
        n_carry     = r_carry;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_res   = r_out_res;
        n_out_dz    = r_out_dz;
        mul_start   = 1'b0;
        mul_a       = r_base;
        mul_b       = r_base;
        div_start   = 1'b0;
        i_req.ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    // capture the beat and dispatch on the operation
                    n_op    = t_op'(i_req.req_type);
                    n_a     = w_a;
                    n_b     = w_b;
                    n_e     = i_req.exponent;
                    n_acc   = WIDTH'(1);
                    n_base  = w_a;
                    n_carry = 1'b0;
                    n_cnt   = '0;
                    n_dz    = 1'b0;
                    n_res   = '0;
                    case (t_op'(i_req.req_type))
                        OP_ADD, OP_SUB: n_state = S_SER;
                        OP_MUL: begin
                            mul_start = 1'b1;
                            mul_a     = w_a;
                            mul_b     = w_b;
                            n_state   = S_MUL;
                        end
                        OP_SQR: begin
                            mul_start = 1'b1;
                            mul_a     = w_a;
                            mul_b     = w_a;
                            n_state   = S_MUL;
                        end
                        OP_DIV: begin
                            if (w_b == '0) begin
                                n_dz    = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        OP_POW:  n_state = S_PCHK;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SER: begin
                // shift one result bit in from the top each cycle
                n_res   = {w_bit, r_res[WIDTH-1:1]};
                n_carry = w_cout;
                n_a     = {1'b0, r_a[WIDTH-1:1]};
                n_b     = {1'b0, r_b[WIDTH-1:1]};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CW'(WIDTH - 1)) n_state = S_DONE;
            end
            S_MUL: begin
                if (mul_done) begin
                    n_res   = mul_prod;
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = div_quo;
                    n_state = S_DONE;
                end
            end
            S_PCHK: begin
                if (r_e == '0) begin
                    n_res   = r_acc;
                    n_state = S_DONE;
                end else if (r_e[0]) begin
                    mul_start = 1'b1;
                    mul_a     = r_acc;
                    mul_b     = r_base;
                    n_state   = S_PMUL;
                end else begin
                    mul_start = 1'b1;
                    n_state   = S_PSQR;
                end
            end
            S_PMUL: begin
                if (mul_done) begin
                    // fold in the base, then square it
                    n_acc     = mul_prod;
                    mul_start = 1'b1;
                    n_state   = S_PSQR;
                end
            end
            S_PSQR: begin
                if (mul_done) begin
                    n_base  = mul_prod;
                    n_e     = {1'b0, r_e[DATA_W-1:1]};
                    n_state = S_PCHK;
                end
            end
            S_DONE: begin
                // hold until the response register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = DATA_W'(r_res);
                    n_out_dz    = r_dz;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result         = r_out_res;
    assign o_rsp.divide_by_zero = r_out_dz;
endmodule

### rtl/iia_checker.sv
// ----------------------------------------------------------------------------
// iia_checker
// Port-level checks on the iterative integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
module iia_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_rsp_result,
    input logic        i_rsp_dz
);
    // hold a stalled response beat
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_result)
            && $stable(i_rsp_dz))
        else $error("response changed while stalled");

    // a zero divisor always yields a zero quotient
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_dz |-> i_rsp_result == 32'd0)
        else $error("divide by zero with nonzero result");

    // one item in flight: drop ready after an accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");
endmodule

bind iterative_integer_alu_core iia_checker u_iia_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_result (o_rsp.result),
    .i_rsp_dz     (o_rsp.divide_by_zero)
);
